FILE: rtl/msf_pkg.sv
package msf_pkg;

  localparam int FRAME_BYTES = 18;
  localparam int IDX_W = 5;
  localparam int BIN_W = 17;
  localparam int DIGITS = 5;
  localparam int BCD_W = 4 * DIGITS;
  localparam int LANES = 7;
  localparam int QUEUE_DEPTH = 2;

  localparam int LANE_MILE = 0;
  localparam int LANE_VOLT = 1;
  localparam int LANE_TEMP = 2;
  localparam int LANE_HOUR = 3;
  localparam int LANE_MIN = 4;
  localparam int LANE_ENERGY = 5;
  localparam int LANE_SPEED = 6;

  localparam logic [IDX_W-1:0] LAST_INDEX = IDX_W'(FRAME_BYTES - 1);
  localparam logic [4:0] STEP_LAST = 5'(BIN_W - 1);

  localparam logic [2:0] EDIT_NONE = 3'd0;
  localparam logic [2:0] EDIT_ALL = 3'd1;
  localparam logic [2:0] EDIT_HOUR = 3'd2;
  localparam logic [2:0] EDIT_MIN_TENS = 3'd3;
  localparam logic [2:0] EDIT_MIN_UNITS = 3'd4;

  typedef enum logic [1:0] {
    FE_IDLE,
    FE_CONV,
    FE_PUSH
  } fe_state_t;

  typedef struct packed {
    logic [7:0] flags;
    logic [3:0] battery;
    logic       temp_neg;
    logic       hour_gt9;
    logic [2:0] edit;
    logic       energy_full;
    logic [2:0] mode;
    logic       blink_on;
    logic [3:0] mile0;
    logic [3:0] mile1;
    logic [3:0] mile2;
    logic [3:0] mile3;
    logic [3:0] mile4;
    logic [3:0] volt1;
    logic [3:0] volt2;
    logic [3:0] temp1;
    logic [3:0] temp2;
    logic [3:0] hour0;
    logic [3:0] min0;
    logic [3:0] min1;
    logic [3:0] energy0;
    logic [3:0] energy1;
    logic [3:0] speed0;
    logic [3:0] speed1;
  } frame_rec_t;

  typedef struct packed {
    logic push;
  } queue_ctl_t;

  function automatic logic [7:0] seg_a(input logic [3:0] d);
    logic [7:0] r;
    case (d)
      4'd0: r = 8'hFA;
      4'd1: r = 8'h60;
      4'd2: r = 8'hD6;
      4'd3: r = 8'hF4;
      4'd4: r = 8'h6C;
      4'd5: r = 8'hBC;
      4'd6: r = 8'hBE;
      4'd7: r = 8'hE0;
      4'd8: r = 8'hFE;
      4'd9: r = 8'hFC;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] seg_b(input logic [3:0] d);
    logic [7:0] r;
    case (d)
      4'd0: r = 8'h5F;
      4'd1: r = 8'h50;
      4'd2: r = 8'h3D;
      4'd3: r = 8'h79;
      4'd4: r = 8'h72;
      4'd5: r = 8'h6B;
      4'd6: r = 8'h6F;
      4'd7: r = 8'h51;
      4'd8: r = 8'h7F;
      4'd9: r = 8'h7B;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] seg_c(input logic [3:0] d);
    logic [7:0] r;
    case (d)
      4'd0: r = 8'hAF;
      4'd1: r = 8'hA0;
      4'd2: r = 8'h6D;
      4'd3: r = 8'hE9;
      4'd4: r = 8'hE2;
      4'd5: r = 8'hCB;
      4'd6: r = 8'hCF;
      4'd7: r = 8'hA1;
      4'd8: r = 8'hEF;
      4'd9: r = 8'hEB;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] bar_code(input logic [3:0] level);
    logic [7:0] r;
    case (level)
      4'd1: r = 8'h80;
      4'd2: r = 8'hC0;
      4'd3: r = 8'hE0;
      4'd4: r = 8'hF0;
      4'd5: r = 8'hF1;
      4'd6: r = 8'hF3;
      4'd7: r = 8'hF7;
      4'd8: r = 8'hFF;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/msf_front.sv
module msf_front import msf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_indicator_flags,
  input  logic [3:0]  in_battery_level,
  input  logic signed [10:0] in_temperature,
  input  logic [4:0]  in_hour,
  input  logic [5:0]  in_minute,
  input  logic [2:0]  in_time_edit,
  input  logic [13:0] in_voltage,
  input  logic [6:0]  in_energy,
  input  logic [16:0] in_mileage,
  input  logic [6:0]  in_speed,
  input  logic [2:0]  in_assist_mode,
  input  logic        q_full,
  output logic        q_push,
  output frame_rec_t  q_rec
);

  fe_state_t state_r, state_nxt;
  logic       hold_v_r, hold_v_nxt;
  logic [3:0] blink_r, blink_nxt;
  logic       accept, load;
  logic [4:0] step_r;

  logic [7:0]  h_flags_r;
  logic [3:0]  h_bat_r;
  logic [10:0] h_temp_r;
  logic [4:0]  h_hour_r;
  logic [5:0]  h_min_r;
  logic [2:0]  h_edit_r;
  logic [13:0] h_volt_r;
  logic [6:0]  h_energy_r;
  logic [16:0] h_mile_r;
  logic [6:0]  h_speed_r;
  logic [2:0]  h_mode_r;
  logic        h_on_r;

  logic [7:0] s_flags_r;
  logic [3:0] s_bat_r;
  logic       s_neg_r;
  logic       s_hgt9_r;
  logic [2:0] s_edit_r;
  logic       s_efull_r;
  logic [2:0] s_mode_r;
  logic       s_on_r;

  logic [BIN_W-1:0] bin_r [LANES];
  logic [BCD_W-1:0] bcd_r [LANES];
  logic [BIN_W-1:0] bin_init [LANES];
  logic [10:0] tmag;

  function automatic logic [BCD_W-1:0] dabble_adj(input logic [BCD_W-1:0] v);
    logic [BCD_W-1:0] r;
    r = v;
    for (int d = 0; d < DIGITS; d++) begin
      if (r[d*4 +: 4] >= 4'd5) begin
        r[d*4 +: 4] = r[d*4 +: 4] + 4'd3;
      end
    end
    return r;
  endfunction

  assign in_ready = !hold_v_r;
  assign accept = in_valid && in_ready;

  always_comb begin
    blink_nxt = blink_r;
    if (accept) begin
      blink_nxt = (blink_r == 4'd9) ? 4'd0 : blink_r + 4'd1;
    end
  end

  always_comb begin
    hold_v_nxt = hold_v_r;
    if (accept) begin
      hold_v_nxt = 1'b1;
    end else if (load) begin
      hold_v_nxt = 1'b0;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      FE_IDLE: begin
        if (hold_v_r) begin
          state_nxt = FE_CONV;
        end
      end
      FE_CONV: begin
        if (step_r == STEP_LAST) begin
          state_nxt = FE_PUSH;
        end
      end
      FE_PUSH: begin
        if (!q_full) begin
          state_nxt = hold_v_r ? FE_CONV : FE_IDLE;
        end
      end
      default: state_nxt = FE_IDLE;
    endcase
  end

  always_comb begin
    load = 1'b0;
    q_push = 1'b0;
    case (state_r)
      FE_IDLE: load = hold_v_r;
      FE_PUSH: begin
        q_push = !q_full;
        load = hold_v_r && !q_full;
      end
      default: begin
        load = 1'b0;
        q_push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FE_IDLE;
      hold_v_r <= 1'b0;
      blink_r <= 4'd0;
      step_r <= 5'd0;
    end else begin
      state_r <= state_nxt;
      hold_v_r <= hold_v_nxt;
      blink_r <= blink_nxt;
      if (load) begin
        step_r <= 5'd0;
      end else if (state_r == FE_CONV) begin
        step_r <= step_r + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      h_flags_r <= in_indicator_flags;
      h_bat_r <= in_battery_level;
      h_temp_r <= in_temperature;
      h_hour_r <= in_hour;
      h_min_r <= in_minute;
      h_edit_r <= in_time_edit;
      h_volt_r <= in_voltage;
      h_energy_r <= in_energy;
      h_mile_r <= in_mileage;
      h_speed_r <= in_speed;
      h_mode_r <= in_assist_mode;
      h_on_r <= (blink_nxt < 4'd5);
    end
  end

  always_comb begin
    tmag = h_temp_r[10] ? 11'(12'h800 - {1'b0, h_temp_r}) : h_temp_r;
    bin_init[LANE_MILE] = h_mile_r;
    bin_init[LANE_VOLT] = BIN_W'(h_volt_r);
    bin_init[LANE_TEMP] = BIN_W'(tmag);
    bin_init[LANE_HOUR] = BIN_W'(h_hour_r);
    bin_init[LANE_MIN] = BIN_W'(h_min_r);
    bin_init[LANE_ENERGY] = BIN_W'(h_energy_r);
    bin_init[LANE_SPEED] = BIN_W'(h_speed_r);
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s_flags_r <= h_flags_r;
      s_bat_r <= h_bat_r;
      s_neg_r <= h_temp_r[10];
      s_hgt9_r <= (h_hour_r > 5'd9);
      s_edit_r <= h_edit_r;
      s_efull_r <= (h_energy_r == 7'd100);
      s_mode_r <= h_mode_r;
      s_on_r <= h_on_r;
    end
  end

  always_ff @(posedge clk) begin
    logic [BCD_W-1:0] adj;
    for (int l = 0; l < LANES; l++) begin
      adj = dabble_adj(bcd_r[l]);
      if (load) begin
        bin_r[l] <= bin_init[l];
        bcd_r[l] <= '0;
      end else if (state_r == FE_CONV) begin
        bcd_r[l] <= {adj[BCD_W-2:0], bin_r[l][BIN_W-1]};
        bin_r[l] <= {bin_r[l][BIN_W-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    q_rec.flags = s_flags_r;
    q_rec.battery = s_bat_r;
    q_rec.temp_neg = s_neg_r;
    q_rec.hour_gt9 = s_hgt9_r;
    q_rec.edit = s_edit_r;
    q_rec.energy_full = s_efull_r;
    q_rec.mode = s_mode_r;
    q_rec.blink_on = s_on_r;
    q_rec.mile0 = bcd_r[LANE_MILE][3:0];
    q_rec.mile1 = bcd_r[LANE_MILE][7:4];
    q_rec.mile2 = bcd_r[LANE_MILE][11:8];
    q_rec.mile3 = bcd_r[LANE_MILE][15:12];
    q_rec.mile4 = bcd_r[LANE_MILE][19:16];
    q_rec.volt1 = bcd_r[LANE_VOLT][7:4];
    q_rec.volt2 = bcd_r[LANE_VOLT][11:8];
    q_rec.temp1 = bcd_r[LANE_TEMP][7:4];
    q_rec.temp2 = bcd_r[LANE_TEMP][11:8];
    q_rec.hour0 = bcd_r[LANE_HOUR][3:0];
    q_rec.min0 = bcd_r[LANE_MIN][3:0];
    q_rec.min1 = bcd_r[LANE_MIN][7:4];
    q_rec.energy0 = bcd_r[LANE_ENERGY][3:0];
    q_rec.energy1 = bcd_r[LANE_ENERGY][7:4];
    q_rec.speed0 = bcd_r[LANE_SPEED][3:0];
    q_rec.speed1 = bcd_r[LANE_SPEED][7:4];
  end

endmodule

FILE: rtl/msf_queue.sv
module msf_queue import msf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  queue_ctl_t ctl,
  input  frame_rec_t wr_rec,
  output logic       full,
  input  logic       pop,
  output logic       not_empty,
  output frame_rec_t rd_rec
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  frame_rec_t mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [PTR_W:0] count_r, count_nxt;

  assign full = (count_r == (PTR_W+1)'(QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign rd_rec = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (ctl.push && !(pop && not_empty)) begin
      count_nxt = count_r + (PTR_W+1)'(1);
    end else if (!ctl.push && pop && not_empty) begin
      count_nxt = count_r - (PTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
      if (ctl.push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop && not_empty) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem_r[wr_ptr_r] <= wr_rec;
    end
  end

endmodule

FILE: rtl/msf_back.sv
module msf_back import msf_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic             cfg_wr_data,
  input  logic             q_not_empty,
  input  frame_rec_t       q_rec,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [IDX_W-1:0] out_byte_index,
  output logic [7:0]       out_byte_value,
  output logic             out_last_byte
);

  logic             clock_r;
  logic [IDX_W-1:0] cnt_r;
  logic             valid_r;
  logic [IDX_W-1:0] idx_r;
  logic [7:0]       val_r;
  logic             last_r;
  logic             issue;
  logic [7:0]       byte_val;
  logic             on, blank_h, blank_mt, blank_mu;
  logic [7:0]       seg_e0, seg_e1, seg_s0, seg_s1;

  assign issue = q_not_empty && (!valid_r || out_ready);
  assign q_pop = issue && (cnt_r == LAST_INDEX);

  always_comb begin
    on = q_rec.blink_on;
    blank_h = on && (q_rec.edit == EDIT_ALL || q_rec.edit == EDIT_HOUR);
    blank_mt = on && (q_rec.edit == EDIT_ALL || q_rec.edit == EDIT_MIN_TENS);
    blank_mu = on && (q_rec.edit == EDIT_ALL || q_rec.edit == EDIT_MIN_UNITS);
    seg_e0 = seg_b(q_rec.energy0);
    seg_e1 = seg_b(q_rec.energy1);
    seg_s0 = seg_b(q_rec.speed0);
    seg_s1 = seg_b(q_rec.speed1);
    byte_val = 8'h00;
    case (cnt_r)
      5'd0: byte_val = seg_b(q_rec.mile0) | 8'h80;
      5'd1: byte_val = seg_c(q_rec.mile1) | ((q_rec.mode == 3'd1) ? 8'h10 : 8'h00);
      5'd2: byte_val = seg_c(q_rec.mile2) | ((q_rec.mode == 3'd2) ? 8'h10 : 8'h00);
      5'd3: byte_val = seg_c(q_rec.mile3) | ((q_rec.mode == 3'd3) ? 8'h10 : 8'h00);
      5'd4: byte_val = seg_c(q_rec.mile4) | ((q_rec.mode == 3'd4) ? 8'h10 : 8'h00);
      5'd5: byte_val = seg_b(q_rec.volt1) | 8'h80;
      5'd6: byte_val = seg_b(q_rec.volt2)
                       | ((q_rec.battery == 4'd0 && on) ? 8'h00 : 8'h80);
      5'd7: byte_val = bar_code(q_rec.battery);
      5'd8: begin
        byte_val = {7'd0, q_rec.flags[0] && on};
        if (clock_r && !blank_h) begin
          byte_val = byte_val | seg_a(q_rec.hour0);
        end
      end
      5'd9: begin
        if (clock_r) begin
          byte_val = (blank_mt ? 8'h00 : seg_a(q_rec.min1))
                     | {7'd0, (q_rec.edit != EDIT_NONE) || on};
        end
      end
      5'd10: begin
        if (clock_r) begin
          byte_val = (blank_mu ? 8'h00 : seg_a(q_rec.min0)) | {7'd0, q_rec.hour_gt9};
        end
      end
      5'd11: byte_val = {q_rec.flags[4], q_rec.flags[5], q_rec.flags[2], q_rec.flags[3],
                         seg_e1[3:0]};
      5'd12: byte_val = {seg_e1[7:4], seg_e0[3:0]}
                        | (q_rec.energy_full ? 8'h80 : 8'h00);
      5'd13: byte_val = {seg_e0[7:4], seg_s1[3:0]} | 8'h80;
      5'd14: byte_val = {seg_s1[7:4], seg_s0[3:0]};
      5'd15: byte_val = {seg_s0[7:4], 1'b1, q_rec.flags[1] && on,
                         q_rec.flags[7], q_rec.flags[6]};
      5'd16: byte_val = seg_a(q_rec.temp1) | 8'h01;
      5'd17: byte_val = seg_a(q_rec.temp2) | (q_rec.temp_neg ? 8'h10 : 8'h00);
      default: byte_val = 8'h00;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clock_r <= 1'b1;
      cnt_r <= '0;
      valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        clock_r <= cfg_wr_data;
      end
      if (issue) begin
        valid_r <= 1'b1;
        cnt_r <= (cnt_r == LAST_INDEX) ? '0 : cnt_r + IDX_W'(1);
      end else if (out_ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      idx_r <= cnt_r;
      val_r <= byte_val;
      last_r <= (cnt_r == LAST_INDEX);
    end
  end

  assign out_valid = valid_r;
  assign out_byte_index = idx_r;
  assign out_byte_value = val_r;
  assign out_last_byte = last_r;

endmodule

FILE: rtl/meter_lcd_segment_frame_unit.sv
// Builds the 18 segment driver bytes of the dashboard LCD from one status word.
// Each status word accepted on the in_ channel yields one frame on the out_
// channel: 18 words with byte_index 0 through 17, the last one flagged by
// out_last_byte. The cfg_ port writes the clock display enable.
// The front part holds one status word in an input register, advances the
// blink counter on acceptance and converts all numbers to decimal digits
// with a shared shift-and-add-three pass. A two-entry queue passes the
// digit record to the back part, which emits one byte a cycle through an
// output register while the receiver keeps out_ready high.
// The digit conversion of one word overlaps the output of the previous frame.
// A receiver stall holds the current byte in the output register; the queue,
// the converter and then the input register fill. in_ready is low whenever the
// input register holds a word that the converter has not yet taken.
// Reset clears the blink counter, empties the queue and sets the clock
// display enable to one.
module meter_lcd_segment_frame_unit import msf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_indicator_flags,
  input  logic [3:0]  in_battery_level,
  input  logic signed [10:0] in_temperature,
  input  logic [4:0]  in_hour,
  input  logic [5:0]  in_minute,
  input  logic [2:0]  in_time_edit,
  input  logic [13:0] in_voltage,
  input  logic [6:0]  in_energy,
  input  logic [16:0] in_mileage,
  input  logic [6:0]  in_speed,
  input  logic [2:0]  in_assist_mode,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [4:0]  out_byte_index,
  output logic [7:0]  out_byte_value,
  output logic        out_last_byte
);

  queue_ctl_t q_ctl;
  frame_rec_t wr_rec, rd_rec;
  logic       q_full, q_pop, q_not_empty;

  msf_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_indicator_flags(in_indicator_flags),
    .in_battery_level  (in_battery_level),
    .in_temperature    (in_temperature),
    .in_hour           (in_hour),
    .in_minute         (in_minute),
    .in_time_edit      (in_time_edit),
    .in_voltage        (in_voltage),
    .in_energy         (in_energy),
    .in_mileage        (in_mileage),
    .in_speed          (in_speed),
    .in_assist_mode    (in_assist_mode),
    .q_full            (q_full),
    .q_push            (q_ctl.push),
    .q_rec             (wr_rec)
  );

  msf_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (q_ctl),
    .wr_rec   (wr_rec),
    .full     (q_full),
    .pop      (q_pop),
    .not_empty(q_not_empty),
    .rd_rec   (rd_rec)
  );

  msf_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .q_not_empty   (q_not_empty),
    .q_rec         (rd_rec),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte_index(out_byte_index),
    .out_byte_value(out_byte_value),
    .out_last_byte (out_last_byte)
  );

endmodule

FILE: tb/sv/meter_lcd_segment_frame_unit_test.sv
module meter_lcd_segment_frame_unit_test import msf_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RESET_CYCLES = 6;
  localparam int CYCLE_LIMIT = 600000;
  localparam int SETTLE_CYCLES = 60;
  localparam int HOLD_CYCLES = 400;
  localparam int BURST_ITEMS = 83;

  localparam int FLAG_LEFT = 0;
  localparam int FLAG_RIGHT = 1;
  localparam int FLAG_CRUISE = 2;
  localparam int FLAG_LIGHT = 3;
  localparam int FLAG_HALL = 4;
  localparam int FLAG_BAR = 5;
  localparam int FLAG_CTRL = 6;
  localparam int FLAG_BRAKE = 7;

  localparam logic [2:0] EDIT_PLAIN5 = 3'd5;
  localparam logic [2:0] EDIT_PLAIN6 = 3'd6;
  localparam logic [2:0] EDIT_PLAIN7 = 3'd7;
  localparam logic [2:0] ASSIST_FIRST = 3'd1;
  localparam logic [2:0] ASSIST_LAST = 3'd4;

  localparam logic [7:0] CLOCK_GLYPH [10] =
    '{8'hFA, 8'h60, 8'hD6, 8'hF4, 8'h6C, 8'hBC, 8'hBE, 8'hE0, 8'hFE, 8'hFC};
  localparam logic [7:0] GAUGE_GLYPH [10] =
    '{8'h5F, 8'h50, 8'h3D, 8'h79, 8'h72, 8'h6B, 8'h6F, 8'h51, 8'h7F, 8'h7B};
  localparam logic [7:0] ODO_GLYPH [10] =
    '{8'hAF, 8'hA0, 8'h6D, 8'hE9, 8'hE2, 8'hCB, 8'hCF, 8'hA1, 8'hEF, 8'hEB};
  localparam logic [7:0] BATTERY_BARS [9] =
    '{8'h00, 8'h80, 8'hC0, 8'hE0, 8'hF0, 8'hF1, 8'hF3, 8'hF7, 8'hFF};

  typedef struct packed {
    logic [7:0]  flags;
    logic [3:0]  battery;
    logic [10:0] temperature;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [2:0]  edit;
    logic [13:0] voltage;
    logic [6:0]  energy;
    logic [16:0] mileage;
    logic [6:0]  speed;
    logic [2:0]  mode;
  } status_t;

  typedef struct packed {
    status_t    st;
    logic       pinned;
    logic [4:0] pin_idx;
    logic [7:0] pin_val;
  } status_row_t;

  typedef struct packed {
    logic [4:0] idx;
    logic [7:0] value;
    logic       last;
  } lcd_word_t;

  typedef logic [FRAME_BYTES-1:0][7:0] frame_t;

  // Rows with a pinned byte carry a value read directly off the display rules.
  localparam int STATUS_ROWS = 20;
  localparam status_row_t STATUS_TABLE [STATUS_ROWS] = '{
    '{'{8'h00, 4'd0, 11'sd0, 5'd0, 6'd0, EDIT_NONE, 14'd0, 7'd0, 17'd0, 7'd0, 3'd0},
      1'b1, 5'd16, 8'hFB},
    '{'{8'hFF, 4'd15, 11'sd999, 5'd23, 6'd59, EDIT_PLAIN7, 14'd9999, 7'd100, 17'd99999,
        7'd99, 3'd7}, 1'b1, 5'd0, 8'hFB},
    '{'{8'hFF, 4'd15, 11'sd1023, 5'd31, 6'd63, EDIT_PLAIN7, 14'd16383, 7'd127, 17'd131071,
        7'd127, 3'd7}, 1'b0, 5'd0, 8'h00},
    '{'{8'h00, 4'd4, -11'sd999, 5'd5, 6'd5, EDIT_NONE, 14'd480, 7'd50, 17'd12345, 7'd25, 3'd2},
      1'b1, 5'd17, 8'hFC},
    '{'{8'h00, 4'd4, 11'h400, 5'd5, 6'd5, EDIT_NONE, 14'd480, 7'd50, 17'd12345, 7'd25, 3'd2},
      1'b1, 5'd16, 8'hD7},
    '{'{8'h01, 4'd0, -11'sd5, 5'd12, 6'd34, EDIT_NONE, 14'd360, 7'd7, 17'd7, 7'd7, 3'd0},
      1'b0, 5'd0, 8'h00},
    '{'{8'h01, 4'd1, 11'sd255, 5'd12, 6'd34, EDIT_ALL, 14'd360, 7'd7, 17'd7, 7'd7, 3'd1},
      1'b0, 5'd0, 8'h00},
    '{'{8'h02, 4'd2, 11'sd255, 5'd12, 6'd34, EDIT_HOUR, 14'd361, 7'd8, 17'd8, 7'd8, 3'd2},
      1'b0, 5'd0, 8'h00},
    '{'{8'h04, 4'd3, 11'sd255, 5'd12, 6'd34, EDIT_MIN_TENS, 14'd362, 7'd9, 17'd9, 7'd9, 3'd3},
      1'b0, 5'd0, 8'h00},
    '{'{8'h08, 4'd4, 11'sd255, 5'd12, 6'd34, EDIT_MIN_UNITS, 14'd363, 7'd10, 17'd10, 7'd10,
        3'd4}, 1'b0, 5'd0, 8'h00},
    '{'{8'h10, 4'd5, 11'sd255, 5'd12, 6'd34, EDIT_PLAIN5, 14'd364, 7'd11, 17'd11, 7'd11, 3'd5},
      1'b0, 5'd0, 8'h00},
    '{'{8'h20, 4'd6, 11'sd255, 5'd12, 6'd34, EDIT_PLAIN6, 14'd365, 7'd12, 17'd12, 7'd12, 3'd6},
      1'b0, 5'd0, 8'h00},
    '{'{8'h40, 4'd7, 11'sd255, 5'd12, 6'd34, EDIT_PLAIN7, 14'd366, 7'd13, 17'd13, 7'd13, 3'd0},
      1'b0, 5'd0, 8'h00},
    '{'{8'h80, 4'd8, 11'sd255, 5'd12, 6'd34, EDIT_NONE, 14'd367, 7'd14, 17'd14, 7'd14, 3'd7},
      1'b1, 5'd7, 8'hFF},
    '{'{8'h03, 4'd0, 11'sd100, 5'd9, 6'd0, EDIT_ALL, 14'd400, 7'd1, 17'd90, 7'd1, 3'd1},
      1'b0, 5'd0, 8'h00},
    '{'{8'h03, 4'd0, 11'sd100, 5'd10, 6'd9, EDIT_HOUR, 14'd400, 7'd1, 17'd90, 7'd1, 3'd4},
      1'b0, 5'd0, 8'h00},
    '{'{8'h00, 4'd8, 11'sd0, 5'd20, 6'd30, EDIT_NONE, 14'd500, 7'd100, 17'd500, 7'd50, 3'd2},
      1'b1, 5'd12, 8'hDF},
    '{'{8'h00, 4'd8, 11'sd0, 5'd20, 6'd30, EDIT_NONE, 14'd9999, 7'd60, 17'd500, 7'd50, 3'd2},
      1'b1, 5'd5, 8'hFB},
    '{'{8'h55, 4'd9, 11'sd10, 5'd9, 6'd59, EDIT_MIN_UNITS, 14'd1234, 7'd99, 17'd10000, 7'd9,
        3'd3}, 1'b0, 5'd0, 8'h00},
    '{'{8'hAA, 4'd8, 11'sd999, 5'd1, 6'd1, EDIT_NONE, 14'd99, 7'd0, 17'd99990, 7'd90, 3'd0},
      1'b1, 5'd16, 8'hFD}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic        cfg_wr_data = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_indicator_flags = '0;
  logic [3:0]  in_battery_level = '0;
  logic signed [10:0] in_temperature = '0;
  logic [4:0]  in_hour = '0;
  logic [5:0]  in_minute = '0;
  logic [2:0]  in_time_edit = '0;
  logic [13:0] in_voltage = '0;
  logic [6:0]  in_energy = '0;
  logic [16:0] in_mileage = '0;
  logic [6:0]  in_speed = '0;
  logic [2:0]  in_assist_mode = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [4:0]  out_byte_index;
  logic [7:0]  out_byte_value;
  logic        out_last_byte;

  lcd_word_t   lcd_words_due [$];
  logic [3:0]  blink_count = '0;
  logic        clock_shown = 1'b1;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  logic        hold_req = 1'b0;
  logic        hold_done = 1'b0;
  int unsigned hold_left = 0;
  int unsigned mismatches = 0;

  meter_lcd_segment_frame_unit i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_indicator_flags (in_indicator_flags),
    .in_battery_level   (in_battery_level),
    .in_temperature     (in_temperature),
    .in_hour            (in_hour),
    .in_minute          (in_minute),
    .in_time_edit       (in_time_edit),
    .in_voltage         (in_voltage),
    .in_energy          (in_energy),
    .in_mileage         (in_mileage),
    .in_speed           (in_speed),
    .in_assist_mode     (in_assist_mode),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_byte_index     (out_byte_index),
    .out_byte_value     (out_byte_value),
    .out_last_byte      (out_last_byte)
  );

  always #5 clk = ~clk;

  function automatic frame_t render_frame(input status_t s, input logic lit,
                                          input logic clock_on);
    frame_t      b;
    logic [11:0] tmag;
    int unsigned deg;
    logic [7:0]  units;
    logic [7:0]  tens;
    b = '0;
    if (s.flags[FLAG_LEFT] && lit) b[8] |= 8'h01;
    if (s.flags[FLAG_RIGHT] && lit) b[15] |= 8'h04;
    if (s.flags[FLAG_CRUISE]) b[11] |= 8'h20;
    if (s.flags[FLAG_LIGHT]) b[11] |= 8'h10;
    if (s.flags[FLAG_HALL]) b[11] |= 8'h80;
    if (s.flags[FLAG_BAR]) b[11] |= 8'h40;
    if (s.flags[FLAG_CTRL]) b[15] |= 8'h01;
    if (s.flags[FLAG_BRAKE]) b[15] |= 8'h02;

    b[6] = 8'h80;
    if (s.battery == 0) begin
      if (lit) b[6] = 8'h00;
    end else if (s.battery <= 8) begin
      b[7] = BATTERY_BARS[s.battery];
    end

    tmag = s.temperature[10] ? 12'd2048 - {1'b0, s.temperature} : {1'b0, s.temperature};
    deg = tmag / 10;
    b[16] = CLOCK_GLYPH[deg % 10] | 8'h01;
    b[17] = CLOCK_GLYPH[(deg / 10) % 10] | (s.temperature[10] ? 8'h10 : 8'h00);

    if (clock_on) begin
      if (s.hour > 9) b[10] |= 8'h01;
      b[8] |= CLOCK_GLYPH[s.hour % 10];
      b[9] |= CLOCK_GLYPH[(s.minute / 10) % 10];
      b[10] |= CLOCK_GLYPH[s.minute % 10];
      if (s.edit != EDIT_NONE) begin
        if (lit) begin
          if (s.edit == EDIT_ALL || s.edit == EDIT_HOUR) b[8] &= 8'h01;
          if (s.edit == EDIT_ALL || s.edit == EDIT_MIN_TENS) b[9] &= 8'h01;
          if (s.edit == EDIT_ALL || s.edit == EDIT_MIN_UNITS) b[10] &= 8'h01;
        end
        b[9] |= 8'h01;
      end else if (lit) begin
        b[9] |= 8'h01;
      end
    end

    b[5] = GAUGE_GLYPH[(s.voltage / 10) % 10] | 8'h80;
    b[6] |= GAUGE_GLYPH[(s.voltage / 100) % 10];

    units = GAUGE_GLYPH[s.energy % 10];
    tens = GAUGE_GLYPH[(s.energy / 10) % 10];
    b[13] |= 8'h80 | (units & 8'hF0);
    b[12] |= (units & 8'h0F) | (tens & 8'hF0);
    b[11] |= tens & 8'h0F;
    if (s.energy == 100) b[12] |= 8'h80;

    b[0] = GAUGE_GLYPH[s.mileage % 10] | 8'h80;
    b[1] = ODO_GLYPH[(s.mileage / 10) % 10];
    b[2] = ODO_GLYPH[(s.mileage / 100) % 10];
    b[3] = ODO_GLYPH[(s.mileage / 1000) % 10];
    b[4] = ODO_GLYPH[(s.mileage / 10000) % 10];

    units = GAUGE_GLYPH[s.speed % 10];
    tens = GAUGE_GLYPH[(s.speed / 10) % 10];
    b[15] |= 8'h08 | (units & 8'hF0);
    b[14] |= (units & 8'h0F) | (tens & 8'hF0);
    b[13] |= tens & 8'h0F;

    if (s.mode >= ASSIST_FIRST && s.mode <= ASSIST_LAST) begin
      b[s.mode] |= 8'h10;
    end else begin
      for (int i = 1; i <= 4; i++) b[i] &= 8'hEF;
    end
    return b;
  endfunction

  function automatic status_t random_status();
    status_t     s;
    logic [95:0] raw;
    int          tenths;
    if ($urandom_range(4) == 0) begin
      raw = {$urandom, $urandom, $urandom};
      s = raw[$bits(status_t)-1:0];
    end else begin
      tenths = int'($urandom_range(1998)) - 999;
      s.flags = 8'($urandom_range(255));
      s.battery = 4'($urandom_range(15));
      s.temperature = tenths[10:0];
      s.hour = 5'($urandom_range(23));
      s.minute = 6'($urandom_range(59));
      s.edit = 3'($urandom_range(7));
      s.voltage = 14'($urandom_range(9999));
      s.energy = ($urandom_range(9) == 0) ? 7'd100 : 7'($urandom_range(100));
      s.mileage = 17'($urandom_range(99999));
      s.speed = 7'($urandom_range(99));
      s.mode = 3'($urandom_range(7));
    end
    return s;
  endfunction

  task automatic send_status(input status_t s, input logic pinned,
                             input logic [4:0] pin_idx, input logic [7:0] pin_val);
    frame_t f;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_indicator_flags <= s.flags;
    in_battery_level <= s.battery;
    in_temperature <= s.temperature;
    in_hour <= s.hour;
    in_minute <= s.minute;
    in_time_edit <= s.edit;
    in_voltage <= s.voltage;
    in_energy <= s.energy;
    in_mileage <= s.mileage;
    in_speed <= s.speed;
    in_assist_mode <= s.mode;
    do @(posedge clk); while (!in_ready);
    blink_count = (blink_count == 4'd9) ? 4'd0 : blink_count + 4'd1;
    f = render_frame(s, blink_count < 5, clock_shown);
    if (pinned) f[pin_idx] = pin_val;
    for (int i = 0; i < FRAME_BYTES; i++) begin
      lcd_words_due.push_back('{5'(i), f[i], 5'(i) == LAST_INDEX});
    end
  endtask

  task automatic send_random(input int unsigned count);
    for (int unsigned k = 0; k < count; k++) send_status(random_status(), 1'b0, '0, '0);
  endtask

  task automatic wait_frames_done();
    in_valid <= 1'b0;
    while (lcd_words_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_clock_enable(input logic enable);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= enable;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    clock_shown = enable;
  endtask

  always @(posedge clk) begin : rx
    lcd_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (lcd_words_due.size() == 0) begin
        $error("word with none pending: byte_index %0d byte_value 0x%02h",
               out_byte_index, out_byte_value);
        mismatches++;
      end else begin
        want = lcd_words_due.pop_front();
        if (out_byte_index !== want.idx) begin
          $error("byte_index: expected %0d, actual %0d", want.idx, out_byte_index);
          mismatches++;
        end
        if (out_byte_value !== want.value) begin
          $error("byte_value: expected 0x%02h, actual 0x%02h", want.value, out_byte_value);
          mismatches++;
        end
        if (out_last_byte !== want.last) begin
          $error("last_byte: expected %0b, actual %0b", want.last, out_last_byte);
          mismatches++;
        end
      end
    end
    if (hold_req && !hold_done) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin : watchdog
    int unsigned ticks;
    ticks = 0;
    while (ticks < CYCLE_LIMIT) begin
      @(posedge clk);
      ticks++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 28;
    recv_idle_pct <= 67;
    write_clock_enable(1'b1);
    for (int r = 0; r < STATUS_ROWS; r++) begin
      send_status(STATUS_TABLE[r].st, STATUS_TABLE[r].pinned, STATUS_TABLE[r].pin_idx,
                  STATUS_TABLE[r].pin_val);
    end
    send_random(BURST_ITEMS);
    wait_frames_done();

    send_idle_pct = 67;
    recv_idle_pct <= 28;
    write_clock_enable(1'b0);
    send_random(BURST_ITEMS);
    wait_frames_done();

    send_idle_pct = 0;
    recv_idle_pct <= 0;
    write_clock_enable(1'b1);
    send_random(10);
    hold_req <= 1'b1;
    send_random(BURST_ITEMS - 10);
    wait_frames_done();

    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
